// ===== design/ihad_pkg.sv =====
// shared types and constants for the in-band header audio deframer
// no dependencies; imported by every module of the block

package ihad_pkg;

	localparam logic [31:0] MAGIC = 32'h5351_4648;

	localparam logic [7:0] DSD_PCM = 8'd0;
	localparam logic [7:0] DSD_DOP = 8'd1;
	localparam logic [7:0] DSD_NATIVE_LE = 8'd2;
	localparam logic [7:0] DSD_NATIVE_BE = 8'd3;

	localparam logic [5:0] DEPTH_16 = 6'd16;
	localparam logic [5:0] DEPTH_24 = 6'd24;
	localparam logic [5:0] DEPTH_32 = 6'd32;
	localparam logic [5:0] DEPTH_DSD = 6'd1;

	localparam int TDATA_W = 112;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_CHANGE = 2'd1,
		KIND_SAME   = 2'd2,
		KIND_SYNC   = 2'd3
	} kind_t;

	// one queued event: for samples data is the raw word, for headers the raw rate
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch;
		logic [31:0] data;
		logic [7:0]  code;
	} ev_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd0: b = MAGIC[31:24];
			2'd1: b = MAGIC[23:16];
			2'd2: b = MAGIC[15:8];
			2'd3: b = MAGIC[7:0];
			default: b = MAGIC[7:0];
		endcase
		return b;
	endfunction

endpackage

// ===== design/inband_header_audio_deframer.sv =====
// top level of the in-band header audio deframer
// depends on ihad_pkg, ihad_front, ihad_queue and ihad_back

// Takes one stream byte per clock on the slave side while the event queue has room, and
// gives at most one result word per byte on the master side: a sample, a format-change or
// same-format record, or a sync error if the stream does not open with the header magic
// (the block then stays halted until reset). The front end holds all parsing state and
// handles every byte in the cycle that takes it; a QUEUE_DEPTH-entry event queue and an
// output register sit between it and the master side, so a stalled consumer only stops
// input once the queue is full. pcm_output_depth is to be written through cfg_we and
// cfg_wdata only while the block is idle; the block does not enforce this. Values other
// than 16, 24 and 32 are dropped.

module inband_header_audio_deframer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [5:0]                    cfg_wdata,      // pcm_output_depth
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,   // stream_byte
	input  logic                          s_axis_tlast,   // end_of_stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// channel_index, sample_value, sample_width, format_rate, format_depth,
	// format_is_dsd, format_dsd_code, format_channels, zero fill
	output logic [ihad_pkg::TDATA_W-1:0]  m_axis_tdata,
	output logic [1:0]                    m_axis_tuser    // result_kind
);
	import ihad_pkg::*;

	logic take;
	logic ev_push;
	ev_t  ev_in;
	ev_t  ev_out;
	logic full;
	logic empty;
	logic pop;

	assign s_axis_tready = !full;
	assign take = s_axis_tvalid && s_axis_tready;

	ihad_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.stream_byte   (s_axis_tdata),
		.end_of_stream (s_axis_tlast),
		.ev_push       (ev_push),
		.ev            (ev_in)
	);

	ihad_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ev_push),
		.din    (ev_in),
		.full   (full),
		.pop    (pop),
		.dout   (ev_out),
		.empty  (empty)
	);

	ihad_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.ev            (ev_out),
		.empty         (empty),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== design/ihad_front.sv =====
// front end: takes stream bytes, tracks headers and audio words, queues events
// depends on ihad_pkg

module ihad_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic [7:0]    stream_byte,
	input  logic          end_of_stream,
	output logic          ev_push,
	output ihad_pkg::ev_t ev
);
	import ihad_pkg::*;

	typedef enum logic [3:0] {
		PH_FIRST  = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_AUDIO  = 4'b0100,
		PH_HALT   = 4'b1000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  hdr_cnt_q, hdr_cnt_d;
	logic [63:0] fields_q, fields_d;
	logic [23:0] win_q, win_d;
	logic [1:0]  fill_q, fill_d;
	logic [23:0] asm_q, asm_d;
	logic [1:0]  sbc_q, sbc_d;
	logic [7:0]  fch_q, fch_d;
	logic [31:0] st_rate_q, st_rate_d;
	logic [7:0]  st_code_q, st_code_d;
	logic [7:0]  st_depth_q, st_depth_d;
	logic [7:0]  st_ch_q, st_ch_d;

	logic [3:0]  fidx;
	logic [31:0] look;
	logic        hit;
	logic [7:0]  feed_b;
	logic [31:0] word;
	logic [8:0]  fch_inc;
	logic        changed;
	logic [2:0]  seq_len;
	logic [2:0]  tot;
	logic [2:0]  idx;
	logic [31:0] fword;
	logic [31:0] asm_ext;
	logic        emit_ok;

	assign fidx = hdr_cnt_q - 4'd4;
	assign look = {win_q, stream_byte};
	assign hit = (fill_q == 2'd3) && (look == MAGIC);
	assign feed_b = win_q[23:16];
	assign word = {feed_b, asm_q};
	assign fch_inc = {1'b0, fch_q} + 9'd1;
	assign changed = (fields_q[63:32] != st_rate_q) || (fields_q[31:24] != st_code_q) ||
			(fields_q[23:16] != st_depth_q);
	assign seq_len = {1'b0, fill_q} + 3'd1;
	assign tot = seq_len + {1'b0, sbc_q};
	assign asm_ext = {8'h00, asm_q};
	assign emit_ok = (st_code_q == DSD_PCM) || (fch_q <= 8'd1);

	// word completed by an end-of-stream flush: old window bytes then the new byte
	always_comb begin
		fword = '0;
		idx = '0;
		for (int j = 0; j < 4; j++) begin
			idx = 3'(seq_len - 3'd1 + {1'b0, sbc_q} - 3'(j));
			if (j < int'(sbc_q)) begin
				fword[8*j +: 8] = asm_ext[8*j +: 8];
			end else begin
				fword[8*j +: 8] = look[{idx[1:0], 3'b000} +: 8];
			end
		end
	end

	always_comb begin
		phase_d = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		fields_d = fields_q;
		win_d = win_q;
		fill_d = fill_q;
		asm_d = asm_q;
		sbc_d = sbc_q;
		fch_d = fch_q;
		st_rate_d = st_rate_q;
		st_code_d = st_code_q;
		st_depth_d = st_depth_q;
		st_ch_d = st_ch_q;
		ev_push = 1'b0;
		ev = '0;
		if (take) begin
			unique case (phase_q)
				PH_FIRST: begin
					if (stream_byte != magic_byte(hdr_cnt_q[1:0])) begin
						ev_push = 1'b1;
						ev.kind = KIND_SYNC;
						phase_d = PH_HALT;
					end else begin
						hdr_cnt_d = hdr_cnt_q + 4'd1;
						if (hdr_cnt_q == 4'd3) begin
							phase_d = PH_HEADER;
						end
					end
				end
				PH_HEADER: begin
					if (hdr_cnt_q >= 4'd4 && hdr_cnt_q <= 4'd11) begin
						fields_d[{fidx[2:0], 3'b000} +: 8] = stream_byte;
					end
					if (hdr_cnt_q == 4'd15) begin
						ev_push = 1'b1;
						ev.kind = changed ? KIND_CHANGE : KIND_SAME;
						ev.ch = fields_q[15:8];
						ev.data = fields_q[63:32];
						ev.code = fields_q[31:24];
						st_ch_d = fields_q[15:8];
						if (changed) begin
							st_rate_d = fields_q[63:32];
							st_code_d = fields_q[31:24];
							st_depth_d = fields_q[23:16];
						end
						phase_d = PH_AUDIO;
						hdr_cnt_d = '0;
						fields_d = '0;
						win_d = '0;
						fill_d = '0;
						asm_d = '0;
						sbc_d = '0;
						fch_d = '0;
					end else begin
						hdr_cnt_d = hdr_cnt_q + 4'd1;
					end
				end
				PH_AUDIO: begin
					if (hit) begin
						// new header inside audio: drop any partial frame
						win_d = '0;
						fill_d = '0;
						asm_d = '0;
						sbc_d = '0;
						fch_d = '0;
						fields_d = '0;
						hdr_cnt_d = 4'd4;
						phase_d = PH_HEADER;
					end else begin
						win_d = look[23:0];
						fill_d = (fill_q == 2'd3) ? 2'd3 : fill_q + 2'd1;
						if (end_of_stream) begin
							if (st_ch_q != 8'd0 && tot >= 3'd4 && emit_ok) begin
								ev_push = 1'b1;
								ev.kind = KIND_SAMPLE;
								ev.ch = fch_q;
								ev.data = fword;
								ev.code = st_code_q;
							end
						end else if (fill_q == 2'd3 && st_ch_q != 8'd0) begin
							if (sbc_q != 2'd3) begin
								asm_d[{sbc_q, 3'b000} +: 8] = feed_b;
								sbc_d = sbc_q + 2'd1;
							end else begin
								asm_d = '0;
								sbc_d = '0;
								fch_d = (fch_inc >= {1'b0, st_ch_q}) ? 8'd0 : fch_inc[7:0];
								if (emit_ok) begin
									ev_push = 1'b1;
									ev.kind = KIND_SAMPLE;
									ev.ch = fch_q;
									ev.data = word;
									ev.code = st_code_q;
								end
							end
						end
					end
				end
				PH_HALT: begin
				end
				default: begin
				end
			endcase
			// end of stream returns to the reset state unless the stream just halted
			if (end_of_stream && phase_d != PH_HALT) begin
				phase_d = PH_FIRST;
				hdr_cnt_d = '0;
				fields_d = '0;
				win_d = '0;
				fill_d = '0;
				asm_d = '0;
				sbc_d = '0;
				fch_d = '0;
				st_rate_d = '0;
				st_code_d = '0;
				st_depth_d = '0;
				st_ch_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			hdr_cnt_q <= '0;
			fields_q <= '0;
			win_q <= '0;
			fill_q <= '0;
			asm_q <= '0;
			sbc_q <= '0;
			fch_q <= '0;
			st_rate_q <= '0;
			st_code_q <= '0;
			st_depth_q <= '0;
			st_ch_q <= '0;
		end else begin
			phase_q <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			fields_q <= fields_d;
			win_q <= win_d;
			fill_q <= fill_d;
			asm_q <= asm_d;
			sbc_q <= sbc_d;
			fch_q <= fch_d;
			st_rate_q <= st_rate_d;
			st_code_q <= st_code_d;
			st_depth_q <= st_depth_d;
			st_ch_q <= st_ch_d;
		end
	end

endmodule

// ===== design/ihad_queue.sv =====
// short event queue between the front end and the output stage
// depends on ihad_pkg for the event type

module ihad_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ihad_pkg::ev_t din,
	output logic          full,
	input  logic          pop,
	output ihad_pkg::ev_t dout,
	output logic          empty
);
	import ihad_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	ev_t           mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + CW'(1);
				2'b01: cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/ihad_back.sv =====
// output stage: turns queued events into result words, holds the depth register
// depends on ihad_pkg

module ihad_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [5:0]                    cfg_wdata,
	input  ihad_pkg::ev_t                 ev,
	input  logic                          empty,
	output logic                          pop,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [ihad_pkg::TDATA_W-1:0]  m_axis_tdata,
	output logic [1:0]                    m_axis_tuser
);
	import ihad_pkg::*;

	logic [5:0]         depth_q;
	logic               valid_q;
	logic [TDATA_W-1:0] data_q;
	kind_t              kind_q;

	logic               load;
	logic [7:0]         ch;
	logic [31:0]        value;
	logic [5:0]         width;
	logic [36:0]        rate;
	logic [5:0]         fdepth;
	logic               is_dsd;
	logic [7:0]         code;
	logic [7:0]         chans;
	logic [TDATA_W-1:0] data_d;

	assign load = !valid_q || m_axis_tready;
	assign pop = load && !empty;

	always_comb begin
		ch = '0;
		value = '0;
		width = '0;
		rate = '0;
		fdepth = '0;
		is_dsd = 1'b0;
		code = '0;
		chans = '0;
		unique case (ev.kind)
			KIND_SAMPLE: begin
				ch = ev.ch;
				if (ev.code == DSD_PCM) begin
					value = ev.data;
					width = 6'd32;
				end else if (ev.code == DSD_DOP) begin
					value = {16'h0000, ev.data[23:8]};
					width = 6'd16;
				end else begin
					value = {ev.data[7:0], ev.data[15:8], ev.data[23:16], ev.data[31:24]};
					width = 6'd32;
				end
			end
			KIND_CHANGE, KIND_SAME: begin
				code = ev.code;
				chans = ev.ch;
				is_dsd = (ev.code != DSD_PCM);
				if (ev.code == DSD_NATIVE_LE || ev.code == DSD_NATIVE_BE) begin
					rate = {ev.data, 5'b00000};
					fdepth = DEPTH_DSD;
				end else if (ev.code == DSD_DOP) begin
					rate = {1'b0, ev.data, 4'b0000};
					fdepth = DEPTH_DSD;
				end else begin
					rate = {5'b00000, ev.data};
					fdepth = depth_q;
				end
			end
			KIND_SYNC: begin
			end
			default: begin
			end
		endcase
		data_d = {6'b000000, chans, code, is_dsd, fdepth, rate, width, value, ch};
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= data_d;
			kind_q <= ev.kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			depth_q <= DEPTH_32;
		end else begin
			if (load) begin
				valid_q <= !empty;
			end
			if (cfg_we && (cfg_wdata == DEPTH_16 || cfg_wdata == DEPTH_24 ||
					cfg_wdata == DEPTH_32)) begin
				depth_q <= cfg_wdata;
			end
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = data_q;
	assign m_axis_tuser = kind_q;

endmodule

// ===== design/ihad_checker.sv =====
// port-level checks for the deframer, bound to the top level
// depends on ihad_pkg and inband_header_audio_deframer

module ihad_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [ihad_pkg::TDATA_W-1:0]  m_axis_tdata,
	input logic [1:0]                    m_axis_tuser
);
	import ihad_pkg::*;

	logic is_fmt;
	assign is_fmt = (m_axis_tuser == KIND_CHANGE) || (m_axis_tuser == KIND_SAME);

	// a stalled result holds still
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// sync error carries nothing else
	a_sync_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_SYNC |-> m_axis_tdata == '0)
		else $error("sync error with nonzero fields");

	// dop payload fits in 16 bits
	a_dop_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_SAMPLE && m_axis_tdata[45:40] == 6'd16 |->
		m_axis_tdata[39:24] == 16'h0000)
		else $error("dop sample wider than 16 bits");

	// dsd flag follows the code in format records
	a_dsd_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && is_fmt |-> m_axis_tdata[89] == (m_axis_tdata[97:90] != DSD_PCM))
		else $error("dsd flag disagrees with code");

endmodule

bind inband_header_audio_deframer ihad_checker u_ihad_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== verif/inband_header_audio_deframer_tb.sv =====
// self-checking testbench for inband_header_audio_deframer: byte streams of format headers
// and audio words in, every result word checked against a cycle-free shadow of the parser
// depends on ihad_pkg and the design sources of the block

module inband_header_audio_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ihad_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int unsigned LONG_HOLD = 300;

	// result word as it sits in m_axis_tdata, lowest field last
	typedef struct packed {
		logic [5:0]  pad;
		logic [7:0]  chans;
		logic [7:0]  code;
		logic        is_dsd;
		logic [5:0]  depth;
		logic [36:0] rate;
		logic [5:0]  width;
		logic [31:0] value;
		logic [7:0]  ch;
	} out_word_t;

	typedef struct packed {
		kind_t     kind;
		out_word_t w;
	} result_t;

	typedef struct packed {
		logic [7:0] b;
		logic       eos;
	} stream_item_t;

	typedef enum logic [1:0] {PS_MAGIC, PS_HEADER, PS_AUDIO, PS_HALTED} parse_state_t;
	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [5:0]           cfg_wdata = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata = '0;
	logic                 s_axis_tlast = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]   m_axis_tdata;
	logic [1:0]           m_axis_tuser;

	inband_header_audio_deframer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #10 clk = ~clk;

	stream_item_t pending_bytes[$];
	result_t      expected_results[$];

	// shadow of the parser state
	parse_state_t sh_state;
	int unsigned  sh_hdr_cnt;
	logic [63:0]  sh_hdr;
	logic [23:0]  sh_win;
	int unsigned  sh_fill;
	logic [31:0]  sh_asm;
	int unsigned  sh_asm_cnt;
	logic [7:0]   sh_frame_ch;
	logic [31:0]  sh_rate;
	logic [7:0]   sh_code;
	logic [7:0]   sh_hdr_depth;
	logic [7:0]   sh_chans;
	logic [5:0]   pcm_depth;

	int unsigned fail_count = 0;
	int unsigned bytes_taken = 0;
	int unsigned queued_bytes = 0;
	int unsigned n_samples = 0, n_change = 0, n_same = 0, n_sync = 0;
	int unsigned cycles = 0;
	int unsigned burst_left = 1, gap_left = 0;
	int unsigned hold_asked = 0, hold_served = 0, hold_left = 0;
	int unsigned rx_mode_left = 0, rx_tick = 0;
	rx_mode_t    rx_mode = RX_OPEN;

	// last format handed out, reused now and then to get same-format records
	bit          fmt_valid = 0;
	logic [7:0]  fmt_depth, fmt_code;
	logic [31:0] fmt_rate;

	task automatic clear_tracking();
		sh_state = PS_MAGIC;
		sh_hdr_cnt = 0;
		sh_hdr = '0;
		sh_win = '0;
		sh_fill = 0;
		sh_asm = '0;
		sh_asm_cnt = 0;
		sh_frame_ch = '0;
		sh_rate = '0;
		sh_code = '0;
		sh_hdr_depth = '0;
		sh_chans = '0;
	endtask

	task automatic assemble_byte(input logic [7:0] b, inout bit got, inout result_t r);
		logic [31:0] w;
		logic [7:0]  ch;
		if (sh_chans == 0)
			return;
		if (sh_asm_cnt < 3) begin
			sh_asm[8*sh_asm_cnt +: 8] = b;
			sh_asm_cnt++;
			return;
		end
		w = {b, sh_asm[23:0]};
		sh_asm = '0;
		sh_asm_cnt = 0;
		ch = sh_frame_ch;
		sh_frame_ch = (int'(ch) + 1 >= int'(sh_chans)) ? 8'd0 : ch + 8'd1;
		// dsd modes only carry the first two channels
		if (sh_code != DSD_PCM && ch > 1)
			return;
		r = '0;
		r.kind = KIND_SAMPLE;
		r.w.ch = ch;
		if (sh_code == DSD_PCM) begin
			r.w.value = w;
			r.w.width = DEPTH_32;
		end else if (sh_code == DSD_DOP) begin
			r.w.value = {16'h0, w[23:8]};
			r.w.width = DEPTH_16;
		end else begin
			r.w.value = {w[7:0], w[15:8], w[23:16], w[31:24]};
			r.w.width = DEPTH_32;
		end
		got = 1;
	endtask

	task automatic close_header(inout bit got, inout result_t r);
		logic [7:0]  ch, depth, code;
		logic [31:0] rate;
		logic [36:0] actual;
		logic [5:0]  fdepth;
		bit          changed;
		ch = sh_hdr[15:8];
		depth = sh_hdr[23:16];
		code = sh_hdr[31:24];
		rate = sh_hdr[63:32];
		changed = rate != sh_rate || code != sh_code || depth != sh_hdr_depth;
		actual = {5'd0, rate};
		fdepth = pcm_depth;
		if (code == DSD_NATIVE_LE || code == DSD_NATIVE_BE) begin
			actual = {rate, 5'd0};
			fdepth = DEPTH_DSD;
		end else if (code == DSD_DOP) begin
			actual = {1'b0, rate, 4'd0};
			fdepth = DEPTH_DSD;
		end
		sh_chans = ch;
		if (changed) begin
			sh_rate = rate;
			sh_code = code;
			sh_hdr_depth = depth;
		end
		r = '0;
		r.kind = changed ? KIND_CHANGE : KIND_SAME;
		r.w.rate = actual;
		r.w.depth = fdepth;
		r.w.is_dsd = code != DSD_PCM;
		r.w.code = code;
		r.w.chans = ch;
		got = 1;
		sh_state = PS_AUDIO;
		sh_hdr_cnt = 0;
		sh_hdr = '0;
		sh_win = '0;
		sh_fill = 0;
		sh_asm = '0;
		sh_asm_cnt = 0;
		sh_frame_ch = '0;
	endtask

	// works out the result word, if any, that one accepted stream byte gives
	task automatic predict_byte(input logic [7:0] b, input logic eos);
		result_t r;
		bit      got;
		int      i;
		got = 0;
		r = '0;
		case (sh_state)
			PS_HALTED:
				return;
			PS_MAGIC: begin
				if (b != MAGIC[8*(3-sh_hdr_cnt) +: 8]) begin
					r.kind = KIND_SYNC;
					expected_results.insert(expected_results.size(), r);
					sh_state = PS_HALTED;
					return;
				end
				sh_hdr_cnt++;
				if (sh_hdr_cnt >= 4)
					sh_state = PS_HEADER;
			end
			PS_HEADER: begin
				if (sh_hdr_cnt >= 4 && sh_hdr_cnt <= 11)
					sh_hdr[8*(sh_hdr_cnt-4) +: 8] = b;
				if (sh_hdr_cnt >= 15)
					close_header(got, r);
				else
					sh_hdr_cnt++;
			end
			default: begin
				if (sh_fill >= 3 && {sh_win, b} == MAGIC) begin
					// new header inside audio: drop the partial frame
					sh_win = '0;
					sh_fill = 0;
					sh_asm = '0;
					sh_asm_cnt = 0;
					sh_frame_ch = '0;
					sh_hdr = '0;
					sh_hdr_cnt = 4;
					sh_state = PS_HEADER;
				end else begin
					if (sh_fill >= 3)
						assemble_byte(sh_win[23:16], got, r);
					sh_win = {sh_win[15:0], b};
					if (sh_fill < 3)
						sh_fill++;
					if (eos)
						for (i = sh_fill; i > 0; i--)
							assemble_byte(sh_win[8*(i-1) +: 8], got, r);
				end
			end
		endcase
		if (eos)
			clear_tracking();
		if (got)
			expected_results.insert(expected_results.size(), r);
	endtask

	always @(posedge clk)
		if (cfg_we && (cfg_wdata == DEPTH_16 || cfg_wdata == DEPTH_24 || cfg_wdata == DEPTH_32))
			pcm_depth = cfg_wdata;

	// driver: bursts of bytes with random gaps
	always @(posedge clk) begin : tx
		stream_item_t item;
		if (s_axis_tvalid && s_axis_tready) begin
			predict_byte(s_axis_tdata, s_axis_tlast);
			bytes_taken++;
		end
		if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_bytes.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				item = pending_bytes.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= item.b;
				s_axis_tlast <= item.eos;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [36:0] want, input logic [36:0] seen);
		if (seen !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
			fail_count++;
		end
	endtask

	// monitor and receiver stall pattern
	always @(posedge clk) begin : rx
		result_t   want;
		out_word_t seen;
		if (m_axis_tvalid && m_axis_tready) begin
			seen = m_axis_tdata;
			if (expected_results.size() == 0) begin
				$error("unexpected result word, kind %0d", m_axis_tuser);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("result_kind", 37'(want.kind), 37'(m_axis_tuser));
				check_field("channel_index", 37'(want.w.ch), 37'(seen.ch));
				check_field("sample_value", 37'(want.w.value), 37'(seen.value));
				check_field("sample_width", 37'(want.w.width), 37'(seen.width));
				check_field("format_rate", want.w.rate, seen.rate);
				check_field("format_depth", 37'(want.w.depth), 37'(seen.depth));
				check_field("format_is_dsd", 37'(want.w.is_dsd), 37'(seen.is_dsd));
				check_field("format_dsd_code", 37'(want.w.code), 37'(seen.code));
				check_field("format_channels", 37'(want.w.chans), 37'(seen.chans));
				case (want.kind)
					KIND_SAMPLE: n_samples++;
					KIND_CHANGE: n_change++;
					KIND_SAME:   n_same++;
					default:     n_sync++;
				endcase
			end
		end
		if (hold_served != hold_asked) begin
			hold_served = hold_asked;
			hold_left = LONG_HOLD;
		end
		if (rx_mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_mode_left = $urandom_range(40, 250);
		end else begin
			rx_mode_left--;
		end
		rx_tick++;
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN:   m_axis_tready <= 1'b1;
				RX_RANDOM: m_axis_tready <= $urandom_range(0, 3) != 0;
				default:   m_axis_tready <= (rx_tick % 7) >= 4;
			endcase
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_results.size());
			$display("** inband_header_audio_deframer: FAILED **");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic eos);
		stream_item_t item;
		item.b = b;
		item.eos = eos;
		pending_bytes.insert(pending_bytes.size(), item);
		queued_bytes++;
	endtask

	// first len bytes of a header, eos on the last one if asked
	task automatic push_header(input logic [7:0] ch, depth, code, input logic [31:0] rate,
		input int len, input bit eos_at_end);
		logic [127:0] h;
		int           i;
		h = {32'($urandom()), rate, code, depth, ch, 8'($urandom()),
			MAGIC[7:0], MAGIC[15:8], MAGIC[23:16], MAGIC[31:24]};
		for (i = 0; i < len; i++)
			push_byte(h[8*i +: 8], eos_at_end && i == len - 1);
	endtask

	task automatic pick_format(output logic [7:0] ch, depth, code, output logic [31:0] rate);
		if (fmt_valid && $urandom_range(0, 2) == 0) begin
			depth = fmt_depth;
			code = fmt_code;
			rate = fmt_rate;
		end else begin
			case ($urandom_range(0, 9))
				4, 5:    code = DSD_DOP;
				6:       code = DSD_NATIVE_LE;
				7:       code = DSD_NATIVE_BE;
				8:       code = 8'($urandom_range(4, 255));
				default: code = DSD_PCM;
			endcase
			case ($urandom_range(0, 7))
				0:       rate = 32'd44100;
				1:       rate = 32'd48000;
				2:       rate = 32'd96000;
				3:       rate = 32'd176400;
				4:       rate = 32'd352800;
				5:       rate = 32'd0;
				6:       rate = 32'hFFFF_FFFF;
				default: rate = $urandom();
			endcase
			case ($urandom_range(0, 4))
				0:       depth = 8'd16;
				1:       depth = 8'd24;
				2:       depth = 8'd32;
				3:       depth = 8'd0;
				default: depth = 8'($urandom());
			endcase
		end
		case ($urandom_range(0, 9))
			0:             ch = 8'd0;
			1:             ch = 8'd1;
			2, 3, 4, 5:    ch = 8'd2;
			6, 7:          ch = 8'($urandom_range(3, 8));
			8:             ch = 8'($urandom());
			default:       ch = 8'd255;
		endcase
		fmt_valid = 1;
		fmt_depth = depth;
		fmt_code = code;
		fmt_rate = rate;
	endtask

	// audio bytes, often whole frames, with the odd magic fragment that is not a header
	task automatic push_audio(input logic [7:0] ch);
		int         n, i;
		logic [7:0] b;
		if (ch != 0 && ch <= 8 && $urandom_range(0, 1) == 1)
			n = 4 * ch * $urandom_range(1, 3) +
				(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
		else
			n = $urandom_range(0, 40);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 49) == 0) begin
				push_byte(MAGIC[31:24], 1'b0);
				push_byte(MAGIC[23:16], 1'b0);
				push_byte(MAGIC[15:8], 1'b0);
				b = 8'($urandom());
				if (b == MAGIC[7:0])
					b = b + 8'd1;
				push_byte(b, 1'b0);
			end else begin
				push_byte(8'($urandom()), 1'b0);
			end
		end
	endtask

	task automatic push_random_stream();
		logic [7:0]  ch, depth, code;
		logic [31:0] rate;
		int          ending;
		ending = $urandom_range(0, 9);
		pick_format(ch, depth, code, rate);
		if (ending == 9) begin
			// stream cut short inside its first header
			push_header(ch, depth, code, rate, $urandom_range(1, 15), 1);
			return;
		end
		push_header(ch, depth, code, rate, 16, 0);
		repeat ($urandom_range(0, 3)) begin
			push_audio(ch);
			pick_format(ch, depth, code, rate);
			push_header(ch, depth, code, rate, 16, 0);
		end
		push_audio(ch);
		pick_format(ch, depth, code, rate);
		case (ending)
			7:       push_header(ch, depth, code, rate, 16, 1);
			8:       push_header(ch, depth, code, rate, $urandom_range(1, 15), 1);
			default: push_byte(8'($urandom()), 1'b1);
		endcase
	endtask

	task automatic push_random_streams(input int unsigned n_items);
		int unsigned start;
		start = queued_bytes;
		while (queued_bytes - start < n_items)
			push_random_stream();
	endtask

	task automatic write_depth(input logic [5:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// waits until the sender has run dry and every expected result is in, then lets the pipe settle
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	initial begin : stimulus
		int p, i;
		logic [7:0] b;
		clear_tracking();
		pcm_depth = DEPTH_32;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// all-zero format header matches the cleared format, then a flush at end of stream
		push_header(8'd1, 8'd0, DSD_PCM, 32'd0, 16, 0);
		for (i = 0; i < 8; i++)
			push_byte(i < 4 ? 8'h00 : 8'hFF, i == 7);
		wait_idle();

		write_depth(DEPTH_16);
		push_random_streams(650);
		wait_idle();

		write_depth(6'd0);
		write_depth(6'd63);
		write_depth(DEPTH_24);
		push_random_streams(650);
		hold_asked++;
		wait_idle();

		write_depth(6'd17);
		write_depth(DEPTH_32);
		push_random_streams(650);
		wait_idle();

		// broken opening magic halts the block for good, so it comes last
		p = $urandom_range(0, 3);
		for (i = 0; i < p; i++)
			push_byte(MAGIC[8*(3-i) +: 8], 1'b0);
		b = MAGIC[8*(3-p) +: 8] ^ 8'($urandom_range(1, 255));
		push_byte(b, 1'b0);
		push_byte(MAGIC[31:24], 1'b0);
		push_byte(8'($urandom()), 1'b1);
		wait_idle();
		repeat (20) @(negedge clk);

		$display("%0d stream bytes taken; checked %0d samples, %0d format changes,",
			bytes_taken, n_samples, n_change);
		$display("%0d same-format records and %0d sync errors", n_same, n_sync);
		if (fail_count == 0) begin
			$display("** inband_header_audio_deframer: PASSED **");
		end else begin
			$display("** inband_header_audio_deframer: FAILED **");
		end
		$finish;
	end

endmodule
